/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while out of reset.
`define HFSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define HFSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked at every edge, reset included.
`define HFSC_ASSERT_ALW(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/hfsc_pkg.sv */
// Package: types, constants and helpers of the half/single converter.
package hfsc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned HManW   = 10;
  localparam int unsigned SManW   = 23;
  localparam int unsigned SExpW   = 8;
  localparam int unsigned HExpW   = 5;
  localparam int unsigned ShamtW  = 4;

  localparam logic [SExpW-1:0] SBias      = 8'd127;
  localparam logic [SExpW-1:0] HToSBias   = 8'd112;  // 127 - 15
  localparam logic [SExpW-1:0] SSubLow    = 8'd103;  // exponent -24
  localparam logic [SExpW-1:0] SNormLow   = 8'd113;  // exponent -14
  localparam logic [SExpW-1:0] SNormHigh  = 8'd142;  // exponent 15
  localparam logic [SExpW-1:0] SExpMax    = 8'hFF;
  localparam logic [HExpW-1:0] HExpMax    = 5'h1F;

  localparam logic [WordW-1:0] SQnanCanon = 32'h7FC0_0000;
  localparam logic [WordW-1:0] SSnanOut   = 32'h7F80_0001;

  localparam logic CMD_H2S = 1'b0;
  localparam logic CMD_S2H = 1'b1;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_INF,
    CLS_NAN
  } cls_e;

  typedef struct packed {
    logic              cmd;
    cls_e              cls;
    logic [ShamtW-1:0] shamt;
    logic [WordW-1:0]  operand;
  } s1_t;

  typedef struct packed {
    logic              cmd;
    cls_e              cls;
    logic [ShamtW-1:0] shamt;
    logic [HManW-1:0]  mant;
    logic [WordW-1:0]  operand;
  } s2_t;

  // Leading zeros of a nonzero 10-bit mantissa.
  function automatic logic [ShamtW-1:0] lzc10(input logic [HManW-1:0] m);
    logic [ShamtW-1:0] n;
    n = '0;
    for (int i = 0; i < HManW; i++) begin
      if (m[i]) begin
        n = ShamtW'(HManW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

/* hdl/half_single_float_converter.sv */
// Top level: pipelined binary16 <-> binary32 bit-pattern converter.
// Stages: decode, shift, assemble; each stage registers its result.
// Throughput: one beat per cycle while out_stall_i is low; stages advance independently, so bubbles
// are squeezed out and in_stall_o rises only when all three stages are full and out_stall_i is high.
// Reset: rst_ni asynchronously clears the stage valid bits; data regs are not reset.
module half_single_float_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] converted_o
);

  logic         s1_vld_q, s2_vld_q, out_vld_q;
  hfsc_pkg::s1_t s1_d, s1_q;
  hfsc_pkg::s2_t s2_d, s2_q;
  logic [31:0]  out_d, out_q;
  logic         en1, en2, en3;

  assign en3        = !out_vld_q || !out_stall_i;
  assign en2        = !s2_vld_q || en3;
  assign en1        = !s1_vld_q || en2;
  assign in_stall_o = !en1;

  // Stage 1: classify and find shift amount
  logic [hfsc_pkg::SExpW-1:0] s_exp;
  logic [hfsc_pkg::HExpW-1:0] h_exp;
  logic [hfsc_pkg::SManW-1:0] s_man;
  logic [hfsc_pkg::HManW-1:0] h_man;

  always_comb begin
    s_exp = operand_i[30:23];
    s_man = operand_i[22:0];
    h_exp = operand_i[14:10];
    h_man = operand_i[9:0];
    s1_d.cmd     = cmd_i;
    s1_d.operand = operand_i;
    s1_d.shamt   = '0;
    if (cmd_i == hfsc_pkg::CMD_H2S) begin
      if (h_exp == '0) begin
        s1_d.cls   = (h_man == '0) ? hfsc_pkg::CLS_ZERO : hfsc_pkg::CLS_SUB;
        s1_d.shamt = hfsc_pkg::lzc10(h_man);
      end else if (h_exp == hfsc_pkg::HExpMax) begin
        s1_d.cls = (h_man == '0) ? hfsc_pkg::CLS_INF : hfsc_pkg::CLS_NAN;
      end else begin
        s1_d.cls = hfsc_pkg::CLS_NORM;
      end
    end else begin
      if (s_exp < hfsc_pkg::SSubLow) begin
        s1_d.cls = hfsc_pkg::CLS_ZERO;
      end else if (s_exp < hfsc_pkg::SNormLow) begin
        s1_d.cls   = hfsc_pkg::CLS_SUB;
        s1_d.shamt = hfsc_pkg::ShamtW'(hfsc_pkg::HToSBias - s_exp);
      end else if (s_exp <= hfsc_pkg::SNormHigh) begin
        s1_d.cls = hfsc_pkg::CLS_NORM;
      end else if (s_exp != hfsc_pkg::SExpMax || s_man == '0) begin
        s1_d.cls = hfsc_pkg::CLS_INF;
      end else begin
        s1_d.cls = hfsc_pkg::CLS_NAN;
      end
    end
  end

  // Stage 2: subnormal shifts
  logic [hfsc_pkg::HManW:0] h_shl;
  logic [23:0]              s_shr;

  always_comb begin
    h_shl = {1'b0, s1_q.operand[9:0]} << ({1'b0, s1_q.shamt} + 5'd1);
    s_shr = {1'b1, s1_q.operand[22:0]} >> ({1'b0, s1_q.shamt} + 5'd14);
    s2_d.cmd     = s1_q.cmd;
    s2_d.cls     = s1_q.cls;
    s2_d.shamt   = s1_q.shamt;
    s2_d.operand = s1_q.operand;
    s2_d.mant    = (s1_q.cmd == hfsc_pkg::CMD_H2S) ? h_shl[9:0] : s_shr[9:0];
  end

  // Stage 3: assemble result
  logic                       sgn;
  logic [hfsc_pkg::SExpW-1:0] sub_exp;
  logic [hfsc_pkg::SExpW-1:0] h2s_exp;
  logic [hfsc_pkg::SExpW-1:0] s2h_exp;
  logic [hfsc_pkg::HManW-1:0] nan_m;

  always_comb begin
    sgn     = (s2_q.cmd == hfsc_pkg::CMD_H2S) ? s2_q.operand[15] : s2_q.operand[31];
    sub_exp = hfsc_pkg::HToSBias - {4'd0, s2_q.shamt};
    h2s_exp = {3'd0, s2_q.operand[14:10]} + hfsc_pkg::HToSBias;
    s2h_exp = s2_q.operand[30:23] - hfsc_pkg::HToSBias;
    nan_m   = s2_q.operand[22:13];
    if (s2_q.operand[22]) begin
      nan_m[9] = 1'b1;
    end else if (nan_m == '0) begin
      nan_m = 10'd1;
    end
    out_d = '0;
    if (s2_q.cmd == hfsc_pkg::CMD_H2S) begin
      case (s2_q.cls)
        hfsc_pkg::CLS_ZERO: out_d = {sgn, 31'd0};
        hfsc_pkg::CLS_SUB:  out_d = {sgn, sub_exp, s2_q.mant, 13'd0};
        hfsc_pkg::CLS_NORM: out_d = {sgn, h2s_exp, s2_q.operand[9:0], 13'd0};
        hfsc_pkg::CLS_INF:  out_d = {sgn, hfsc_pkg::SExpMax, 23'd0};
        hfsc_pkg::CLS_NAN:  out_d = s2_q.operand[9] ? hfsc_pkg::SQnanCanon
                                                    : hfsc_pkg::SSnanOut;
        default:            out_d = '0;
      endcase
    end else begin
      case (s2_q.cls)
        hfsc_pkg::CLS_ZERO: out_d = {16'd0, sgn, 15'd0};
        hfsc_pkg::CLS_SUB:  out_d = {16'd0, sgn, 5'd0, s2_q.mant};
        hfsc_pkg::CLS_NORM: out_d = {16'd0, sgn, s2h_exp[4:0], s2_q.operand[22:13]};
        hfsc_pkg::CLS_INF:  out_d = {16'd0, sgn, hfsc_pkg::HExpMax, 10'd0};
        hfsc_pkg::CLS_NAN:  out_d = {16'd0, sgn, hfsc_pkg::HExpMax, nan_m};
        default:            out_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q  <= in_valid_i;
      if (en2) s2_vld_q  <= s1_vld_q;
      if (en3) out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) s1_q  <= s1_d;
    if (en2 && s1_vld_q)   s2_q  <= s2_d;
    if (en3 && s2_vld_q)   out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign converted_o = out_q;

endmodule

/* hdl/hfsc_checker.sv */
// Port-level checker for the converter, bound to the top level.
`include "assert_macros.svh"

module hfsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] converted_o
);

  logic in_beat;
  logic out_held;
  logic out_go;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_go   = !out_stall_i;

  `HFSC_ASSERT_ALW(a_rst_no_beat, clk_i, !rst_ni ##1 !rst_ni, !out_valid_o)
  `HFSC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(converted_o))
  `HFSC_ASSERT_IMP(a_stall_full, clk_i, rst_ni, in_stall_o, out_held)
  `HFSC_ASSERT_NXT(a_latency, clk_i, rst_ni, in_beat ##1 out_go ##1 out_go, out_valid_o)

endmodule

bind half_single_float_converter hfsc_checker u_hfsc_checker (.*);
